[design/bic_pkg.sv]
// shared types and constants of the blob intensity centroid block
package bic_pkg;

   localparam int COORD_LIMIT = 2048;
   localparam int FRAC_BITS   = 8;
   localparam int SUM_W       = 20;
   localparam int MOM_W       = 26;
   localparam int OUT_W       = 19;
   localparam int DIV_W       = MOM_W + FRAC_BITS;
   localparam int DIV_STEPS   = DIV_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);

   localparam longint LIMIT_RAW = (longint'(COORD_LIMIT) << FRAC_BITS) - 1;
   localparam longint OUT_MAX   = (longint'(1) << OUT_W) - 1;
   localparam longint SAT_LIMIT = (LIMIT_RAW < OUT_MAX) ? LIMIT_RAW : OUT_MAX;
   localparam logic [DIV_W:0] SAT_VALUE = (DIV_W + 1)'(SAT_LIMIT);

   localparam logic [1:0] SHAPE_NORMAL = 2'd0;
   localparam logic [1:0] SHAPE_ROW    = 2'd1;
   localparam logic [1:0] SHAPE_COLUMN = 2'd2;
   localparam logic [1:0] SHAPE_SINGLE = 2'd3;

   typedef struct packed {
      logic [5:0]  col_offset;
      logic [5:0]  row_offset;
      logic [7:0]  brightness;
      logic        in_label;
      logic [10:0] box_left;
      logic [10:0] box_top;
      logic [6:0]  box_width;
      logic [6:0]  box_height;
      logic [12:0] box_area;
      logic        last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [OUT_W-1:0] center_x;
      logic [OUT_W-1:0] center_y;
      logic [1:0]       shape_flag;
      logic             zero_weight;
   } centroid_type;

   typedef struct packed {
      logic accumulate;
      logic start;
      logic step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

[design/bic_channels.sv]
// valid/ready channel interfaces for pixel items and centroid items
interface bic_req_if import bic_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bic_rsp_if import bic_pkg::*; ();
   logic         valid;
   logic         ready;
   centroid_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/blob_intensity_centroid.sv]
// top level of the blob intensity weighted centroid block
// Pixel items of one blob's bounding box enter on req_if, one per cycle while
// req_if.ready is high. Labelled pixels add their brightness and brightness
// weighted column and row offsets to three accumulators. The item that
// carries last_pixel closes the blob: its sums go to two restoring dividers
// (one for x, one for y) that produce one quotient bit per cycle over the
// 34-bit dividend of a 26-bit moment with 8 fraction bits. A final state adds
// the box corner, clamps and loads the output register once that register is
// free, and the centroid item then shows on rsp_if. req_if.ready is low from
// the last pixel until the output register is loaded. The output register
// holds while rsp_if.ready is low; pixels of the next blob are still taken
// then, and only the next blob's result waits for the register to drain.
// Reset (synchronous, active high) clears the accumulators, the controller
// and the output valid; no item is in flight.
module blob_intensity_centroid import bic_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bic_req_if.sink   req_if,
   bic_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   bic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.data.last_pixel),
      .status    (status),
      .req_ready (req_if.ready),
      .cmd       (cmd)
   );

   bic_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pix       (req_if.data),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_if.data),
      .status    (status)
   );

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.load))
      else $error("result valid rose without a load");

   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.data.last_pixel) |=> !req_if.ready)
      else $error("pixel taken right after a last pixel");

   a_no_take_while_dividing: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_if.ready)
      else $error("pixel taken during division");

   a_zero_weight_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.data.zero_weight) |->
         (rsp_if.data.center_x[7:0] == 8'd0 && rsp_if.data.center_y[7:0] == 8'd0))
      else $error("zero weight result has a fractional offset");

endmodule

[design/bic_ctrl.sv]
// controller: accumulate, divide and hand-off sequencing
module bic_ctrl import bic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   localparam logic [1:0] S_ACC = 2'd0;
   localparam logic [1:0] S_DIV = 2'd1;
   localparam logic [1:0] S_FIN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_ready = (state_ff == S_ACC);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd.accumulate = 1'b0;
      cmd.start      = 1'b0;
      cmd.step       = 1'b0;
      cmd.load       = 1'b0;
      case (state_ff)
         S_ACC: begin
            cmd.accumulate = accept;
            if (accept && req_last) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // wait until the output register is free
            if (!status.out_busy) begin
               cmd.load = 1'b1;
               state_in = S_ACC;
            end
         end
         default: begin
            state_in = S_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[design/bic_dp.sv]
// datapath: moment accumulators, two restoring dividers, output register
module bic_dp import bic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  pixel_type    pix,
   input  logic         out_ready,
   output logic         out_valid,
   output centroid_type out_data,
   output status_type   status
);

   logic [SUM_W-1:0] weight_sum_ff, weight_sum_in, weight_add;
   logic [MOM_W-1:0] moment_x_ff, moment_x_in, moment_x_add;
   logic [MOM_W-1:0] moment_y_ff, moment_y_in, moment_y_add;
   logic [13:0]      prod_x, prod_y;
   logic [7:0]       bright_eff;

   logic [SUM_W-1:0] div_sum_ff;
   logic [SUM_W-1:0] rem_x_ff, rem_y_ff;
   logic [DIV_W-1:0] quo_x_ff, quo_y_ff;
   logic [10:0]      corner_x_ff, corner_y_ff;
   logic [1:0]       shape_ff, shape_in;
   logic             zero_ff;

   logic [SUM_W:0]   shift_x, shift_y, diff_x, diff_y;
   logic             ge_x, ge_y;

   logic             out_valid_ff;
   centroid_type     out_data_ff;
   logic [DIV_W-1:0] quo_x_eff, quo_y_eff;
   logic [DIV_W:0]   pos_x, pos_y;

   assign bright_eff = pix.in_label ? pix.brightness : 8'd0;
   assign prod_x     = {6'd0, bright_eff} * {8'd0, pix.col_offset};
   assign prod_y     = {6'd0, bright_eff} * {8'd0, pix.row_offset};
   assign weight_add = weight_sum_ff + {{(SUM_W - 8){1'b0}}, bright_eff};
   assign moment_x_add = moment_x_ff + {{(MOM_W - 14){1'b0}}, prod_x};
   assign moment_y_add = moment_y_ff + {{(MOM_W - 14){1'b0}}, prod_y};

   always_comb begin
      weight_sum_in = weight_sum_ff;
      moment_x_in   = moment_x_ff;
      moment_y_in   = moment_y_ff;
      if (cmd.start) begin
         weight_sum_in = '0;
         moment_x_in   = '0;
         moment_y_in   = '0;
      end else if (cmd.accumulate) begin
         weight_sum_in = weight_add;
         moment_x_in   = moment_x_add;
         moment_y_in   = moment_y_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_sum_ff <= '0;
         moment_x_ff   <= '0;
         moment_y_ff   <= '0;
      end else begin
         weight_sum_ff <= weight_sum_in;
         moment_x_ff   <= moment_x_in;
         moment_y_ff   <= moment_y_in;
      end
   end

   always_comb begin
      if (pix.box_area == 13'd1) begin
         shape_in = SHAPE_SINGLE;
      end else if (pix.box_width == 7'd1) begin
         shape_in = SHAPE_COLUMN;
      end else if (pix.box_height == 7'd1) begin
         shape_in = SHAPE_ROW;
      end else begin
         shape_in = SHAPE_NORMAL;
      end
   end

   // one quotient bit per cycle for each axis
   assign shift_x = {rem_x_ff, quo_x_ff[DIV_W-1]};
   assign shift_y = {rem_y_ff, quo_y_ff[DIV_W-1]};
   assign ge_x    = shift_x >= {1'b0, div_sum_ff};
   assign ge_y    = shift_y >= {1'b0, div_sum_ff};
   assign diff_x  = shift_x - {1'b0, div_sum_ff};
   assign diff_y  = shift_y - {1'b0, div_sum_ff};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         div_sum_ff  <= weight_add;
         rem_x_ff    <= '0;
         rem_y_ff    <= '0;
         quo_x_ff    <= {moment_x_add, {FRAC_BITS{1'b0}}};
         quo_y_ff    <= {moment_y_add, {FRAC_BITS{1'b0}}};
         corner_x_ff <= pix.box_left;
         corner_y_ff <= pix.box_top;
         shape_ff    <= shape_in;
         zero_ff     <= (weight_add == '0);
      end else if (cmd.step) begin
         rem_x_ff <= ge_x ? diff_x[SUM_W-1:0] : shift_x[SUM_W-1:0];
         rem_y_ff <= ge_y ? diff_y[SUM_W-1:0] : shift_y[SUM_W-1:0];
         quo_x_ff <= {quo_x_ff[DIV_W-2:0], ge_x};
         quo_y_ff <= {quo_y_ff[DIV_W-2:0], ge_y};
      end
   end

   // corner plus offset, clamped to the coordinate limit
   assign quo_x_eff = zero_ff ? '0 : quo_x_ff;
   assign quo_y_eff = zero_ff ? '0 : quo_y_ff;
   assign pos_x = {{(DIV_W + 1 - 11 - FRAC_BITS){1'b0}}, corner_x_ff, {FRAC_BITS{1'b0}}}
                  + {1'b0, quo_x_eff};
   assign pos_y = {{(DIV_W + 1 - 11 - FRAC_BITS){1'b0}}, corner_y_ff, {FRAC_BITS{1'b0}}}
                  + {1'b0, quo_y_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_data_ff.center_x    <= (pos_x > SAT_VALUE) ? SAT_VALUE[OUT_W-1:0]
                                                        : pos_x[OUT_W-1:0];
         out_data_ff.center_y    <= (pos_y > SAT_VALUE) ? SAT_VALUE[OUT_W-1:0]
                                                        : pos_y[OUT_W-1:0];
         out_data_ff.shape_flag  <= shape_ff;
         out_data_ff.zero_weight <= zero_ff;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_data        = out_data_ff;
   assign status.out_busy = out_valid_ff && !out_ready;

endmodule
